// ----- src/idw_pkg.sv -----
// Shared types and constants of the inverse distance weighting interpolator.
package idw_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WSUM_W = 64;
  localparam int unsigned WTSUM_W = 40;

  // Neighbors taken per query; the rest of a long run is ignored
  localparam int unsigned MAX_NEIGHBORS = 16;
  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);

  // Radix-2 divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W = WTSUM_W + 1;

  localparam logic [DATA_W-1:0] TOL_RESET = '1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_AVG = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXACT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECIP,
    S_ACCUM,
    S_FINAL,
    S_QUOT,
    S_DONE
  } idw_state_t;

endpackage

// ----- src/idw_in_if.sv -----
// Neighbor input channel: valid/ready with distance, value and end-of-run flag.
interface idw_in_if
  import idw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        distance;
  logic signed [DATA_W-1:0] sample_value;
  logic                     last;

  modport source(output valid, distance, sample_value, last, input ready);
  modport sink(input valid, distance, sample_value, last, output ready);
endinterface

// ----- src/idw_out_if.sv -----
// Result channel: valid/ready with interpolated value and status.
interface idw_out_if
  import idw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interpolated;
  logic [STAT_W-1:0]        status;

  modport source(output valid, interpolated, status, input ready);
  modport sink(input valid, interpolated, status, output ready);
endinterface

// ----- src/idw_cfg_if.sv -----
// Configuration write channel carrying the tolerance register.
interface idw_cfg_if
  import idw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] tolerance;

  modport source(output valid, tolerance, input ready);
  modport sink(input valid, tolerance, output ready);
endinterface

// ----- src/inverse_distance_weight_interp.sv -----
// Neighbor item with a weight to compute: accept, divider/multiplier steps in S_RECIP, add.
// Dropped, exact-hit or over-count neighbor: accept only. A last item then passes S_FINAL,
// and the final quotient steps in S_QUOT if an average is formed, before the result registers.
// The single radix-2 divider, one bit per cycle, sets the pace; the multiply rides along.
// The result register lets the next query start while a result waits to be taken.
// rst_n (synchronous, active low) clears the accumulators and sets tolerance to all ones.
module inverse_distance_weight_interp
  import idw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  idw_in_if.sink    in_item,
  idw_out_if.source out_item,
  idw_cfg_if.sink   cfg_wr
);

  idw_state_t state_r, state_nxt;

  logic [DATA_W-1:0]        tol_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     kept_r, kept_nxt;
  logic                     exact_r, exact_nxt;
  logic [DATA_W-1:0]        exval_r, exval_nxt;
  logic signed [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [WTSUM_W-1:0]       wtsum_r, wtsum_nxt;
  logic                     last_r, last_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [WTSUM_W-1:0]       div_r, div_nxt;
  logic [DATA_W-1:0]        dvd_r, dvd_nxt;
  logic [DATA_W-1:0]        q_r, q_nxt;
  logic signed [WSUM_W-1:0] prod_r, prod_nxt;
  logic                     sat_r, sat_nxt;
  logic                     neg_r, neg_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [DATA_W-1:0]        res_r, res_nxt;
  logic [STAT_W-1:0]        st_r, st_nxt;
  logic                     ov_r, ov_nxt;
  logic [DATA_W-1:0]        oval_r, oval_nxt;
  logic [STAT_W-1:0]        ost_r, ost_nxt;

  // Divider step and Horner multiply on the fresh quotient bit
  logic [REM_W-1:0]         shifted;
  logic                     ge;
  logic                     qbit;
  logic [REM_W-1:0]         rem_step;
  logic [DATA_W-1:0]        q_step;
  logic signed [WSUM_W-1:0] prod_step;

  // Accumulation and final-division setup
  logic signed [WSUM_W:0]   sum65;
  logic [WTSUM_W:0]         wt41;
  logic [WSUM_W-1:0]        mag;
  logic                     in_acc;
  logic                     take;

  assign shifted   = {rem_r[REM_W-2:0], dvd_r[DATA_W-1]};
  assign ge        = shifted >= {1'b0, div_r};
  assign qbit      = sat_r | ge;
  assign rem_step  = ge ? (shifted - {1'b0, div_r}) : shifted;
  assign q_step    = {q_r[DATA_W-2:0], qbit};
  assign prod_step = {prod_r[WSUM_W-2:0], 1'b0}
                   + (qbit ? {{(WSUM_W-DATA_W){v_r[DATA_W-1]}}, v_r} : {WSUM_W{1'b0}});

  assign sum65 = {wsum_r[WSUM_W-1], wsum_r} + {prod_r[WSUM_W-1], prod_r};
  assign wt41  = {1'b0, wtsum_r} + {{(REM_W-DATA_W){1'b0}}, q_r};
  assign mag   = wsum_r[WSUM_W-1] ? (~wsum_r + 1'b1) : wsum_r;

  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc        = in_item.valid & in_item.ready;
  assign take          = cnt_r < CNT_W'(MAX_NEIGHBORS);

  assign cfg_wr.ready = 1'b1;

  assign out_item.valid        = ov_r;
  assign out_item.interpolated = oval_r;
  assign out_item.status       = ost_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tol_r   <= TOL_RESET;
      cnt_r   <= '0;
      kept_r  <= 1'b0;
      exact_r <= 1'b0;
      wsum_r  <= '0;
      wtsum_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid) begin
        tol_r <= cfg_wr.tolerance;
      end
      cnt_r   <= cnt_nxt;
      kept_r  <= kept_nxt;
      exact_r <= exact_nxt;
      wsum_r  <= wsum_nxt;
      wtsum_r <= wtsum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    exval_r <= exval_nxt;
    last_r  <= last_nxt;
    v_r     <= v_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    dvd_r   <= dvd_nxt;
    q_r     <= q_nxt;
    prod_r  <= prod_nxt;
    sat_r   <= sat_nxt;
    neg_r   <= neg_nxt;
    ovf_r   <= ovf_nxt;
    step_r  <= step_nxt;
    res_r   <= res_nxt;
    st_r    <= st_nxt;
    oval_r  <= oval_nxt;
    ost_r   <= ost_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kept_nxt  = kept_r;
    exact_nxt = exact_r;
    exval_nxt = exval_r;
    wsum_nxt  = wsum_r;
    wtsum_nxt = wtsum_r;
    last_nxt  = last_r;
    v_nxt     = v_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    dvd_nxt   = dvd_r;
    q_nxt     = q_r;
    prod_nxt  = prod_r;
    sat_nxt   = sat_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    step_nxt  = step_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    ov_nxt    = ov_r & ~out_item.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_item.last;
          if (in_item.last) begin
            state_nxt = S_FINAL;
          end
          if (take) begin
            cnt_nxt = cnt_r + 1'b1;
            if (in_item.distance <= tol_r) begin
              kept_nxt = 1'b1;
              if (!exact_r) begin
                if (in_item.distance == '0) begin
                  exact_nxt = 1'b1;
                  exval_nxt = in_item.sample_value;
                end else begin
                  // 2^32 / d: remainder starts at the leading one, zeros shift in
                  rem_nxt   = REM_W'(1);
                  div_nxt   = {{(WTSUM_W-DATA_W){1'b0}}, in_item.distance};
                  dvd_nxt   = '0;
                  sat_nxt   = (in_item.distance == DATA_W'(1));
                  v_nxt     = in_item.sample_value;
                  prod_nxt  = '0;
                  q_nxt     = '0;
                  step_nxt  = '0;
                  state_nxt = S_RECIP;
                end
              end
            end
          end
        end
      end

      S_RECIP: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[DATA_W-2:0], 1'b0};
        q_nxt    = q_step;
        prod_nxt = prod_step;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ACCUM;
        end
      end

      S_ACCUM: begin
        // Saturating adds into both sums
        if (sum65[WSUM_W] != sum65[WSUM_W-1]) begin
          wsum_nxt = sum65[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
        end else begin
          wsum_nxt = sum65[WSUM_W-1:0];
        end
        wtsum_nxt = wt41[WTSUM_W] ? {WTSUM_W{1'b1}} : wt41[WTSUM_W-1:0];
        state_nxt = last_r ? S_FINAL : S_IDLE;
      end

      S_FINAL: begin
        priority if (exact_r) begin
          res_nxt   = exval_r;
          st_nxt    = ST_EXACT;
          state_nxt = S_DONE;
        end else if (!kept_r) begin
          res_nxt   = '0;
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else if (wtsum_r == '0) begin
          res_nxt   = '0;
          st_nxt    = ST_AVG;
          state_nxt = S_DONE;
        end else begin
          // |sum| / weight: upper half seeds the remainder, lower half shifts in
          neg_nxt   = wsum_r[WSUM_W-1];
          ovf_nxt   = {{(WTSUM_W-DATA_W){1'b0}}, mag[WSUM_W-1:DATA_W]} >= wtsum_r;
          rem_nxt   = {{(REM_W-DATA_W){1'b0}}, mag[WSUM_W-1:DATA_W]};
          dvd_nxt   = mag[DATA_W-1:0];
          div_nxt   = wtsum_r;
          sat_nxt   = 1'b0;
          v_nxt     = '0;
          prod_nxt  = '0;
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = S_QUOT;
        end
      end

      S_QUOT: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[DATA_W-2:0], 1'b0};
        q_nxt    = q_step;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          // Clamp to the signed 32-bit range
          if (neg_r) begin
            if (ovf_r || (q_step > {1'b1, {(DATA_W-1){1'b0}}})) begin
              res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
              res_nxt = ~q_step + 1'b1;
            end
          end else begin
            if (ovf_r || q_step[DATA_W-1]) begin
              res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
              res_nxt = q_step;
            end
          end
          st_nxt    = ST_AVG;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand over to the result register, then clear the query
        if (!ov_r || out_item.ready) begin
          ov_nxt    = 1'b1;
          oval_nxt  = res_r;
          ost_nxt   = st_r;
          cnt_nxt   = '0;
          kept_nxt  = 1'b0;
          exact_nxt = 1'b0;
          exval_nxt = '0;
          wsum_nxt  = '0;
          wtsum_nxt = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/idw_checker.sv -----
// Port-level assertions for the interpolator, bound to the top level.
module idw_checker
  import idw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_interpolated,
  input logic [STAT_W-1:0] out_status
);

  // A result that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interpolated) && $stable(out_status))
    else $error("result changed while stalled");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_AVG || out_status == ST_EXACT || out_status == ST_NONE))
    else $error("undefined status code");

  // A query with no neighbor kept reports zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_interpolated == '0)
    else $error("nonzero value with no neighbor kept");

  // Closing a query blocks the input for at least the next cycle
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after a closing item");

endmodule

bind inverse_distance_weight_interp idw_checker u_idw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_item.valid),
  .in_ready         (in_item.ready),
  .in_last          (in_item.last),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_interpolated (out_item.interpolated),
  .out_status       (out_item.status)
);
